[rtl/core/slsd_pkg.sv]
// Shared types, constants and the log2 fraction table for sound level statistics.
package slsd_pkg;

  typedef enum logic [1:0] {
    BandLow    = 2'd0,
    BandMedium = 2'd1,
    BandHigh   = 2'd2
  } band_e;

  typedef enum logic [2:0] {
    CfgLedThreshold   = 3'd0,
    CfgBaselineSample = 3'd1,
    CfgReferenceLevel = 3'd2,
    CfgMinValidSample = 3'd3,
    CfgMediumStart    = 3'd4,
    CfgHighStart      = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LevelW = 11;
  localparam int unsigned FloorW = 14;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned ExpW = 5;
  localparam int unsigned FracW = 16;
  localparam int unsigned LogW = 21;
  localparam int unsigned ProdW = 44;
  localparam int unsigned SumW = 12;
  localparam int unsigned OutTimeW = 32;

  localparam int unsigned ResetLedThreshold = 800;
  localparam int unsigned ResetBaseline = 792;
  localparam int unsigned ResetReference = 400;
  localparam int unsigned ResetMinValid = 50;
  localparam int unsigned ResetMediumStart = 600;
  localparam int unsigned ResetHighStart = 900;

  localparam logic [LevelW-1:0] LevelMin = 11'd300;
  localparam logic [LevelW-1:0] LevelMax = 11'd1100;
  localparam logic [FloorW-1:0] FloorNone = 14'd9990;
  localparam logic [ProdW-1:0] LogScale = 44'd3945660;

  localparam int unsigned QueueDepth = 2;

  localparam logic [16:0] Log2Frac [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

endpackage

[rtl/core/slsd_front.sv]
// Front end: configuration registers, log level pipeline, band and flag classification.
module slsd_front #(
  parameter int unsigned SampleBits = 12,
  parameter int unsigned CfgW = 12,
  parameter int unsigned ItemW = 43
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slsd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]                     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SampleBits-1:0]               sample_i,
  input  logic [slsd_pkg::ElapsedW-1:0]       elapsed_ms_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output logic [ItemW-1:0]                    item_data_o
);

  localparam int unsigned XW = CfgW + 1;
  localparam int unsigned SideW = SampleBits + slsd_pkg::ElapsedW + 2;
  localparam int unsigned NumStages = 5;

  logic [CfgW-1:0] thr_q, base_q, minv_q;
  logic [slsd_pkg::LevelW-1:0] ref_q, med_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= CfgW'(slsd_pkg::ResetLedThreshold);
      base_q <= CfgW'(slsd_pkg::ResetBaseline);
      minv_q <= CfgW'(slsd_pkg::ResetMinValid);
      ref_q  <= slsd_pkg::LevelW'(slsd_pkg::ResetReference);
      med_q  <= slsd_pkg::LevelW'(slsd_pkg::ResetMediumStart);
      high_q <= slsd_pkg::LevelW'(slsd_pkg::ResetHighStart);
    end else if (cfg_we_i) begin
      unique case (slsd_pkg::cfg_idx_e'(cfg_idx_i))
        slsd_pkg::CfgLedThreshold:   thr_q  <= CfgW'(cfg_wdata_i[SampleBits-1:0]);
        slsd_pkg::CfgBaselineSample: base_q <= CfgW'(cfg_wdata_i[SampleBits-1:0]);
        slsd_pkg::CfgReferenceLevel: ref_q  <= cfg_wdata_i[slsd_pkg::LevelW-1:0];
        slsd_pkg::CfgMinValidSample: minv_q <= CfgW'(cfg_wdata_i[SampleBits-1:0]);
        slsd_pkg::CfgMediumStart:    med_q  <= cfg_wdata_i[slsd_pkg::LevelW-1:0];
        slsd_pkg::CfgHighStart:      high_q <= cfg_wdata_i[slsd_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  logic [NumStages-1:0] vld_q;
  logic                 advance;

  assign advance      = !vld_q[NumStages-1] || item_ready_i;
  assign in_ready_o   = advance;
  assign item_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // stage A: flags and distance from baseline
  logic [CfgW-1:0]  sx, delta;
  logic [SideW-1:0] side_in;
  logic [XW-1:0]    x_d;

  always_comb begin
    sx      = CfgW'(sample_i);
    delta   = (sx >= base_q) ? sx - base_q : base_q - sx;
    x_d     = XW'(delta) + XW'(1);
    side_in = {sample_i, elapsed_ms_i, (sx > thr_q), (sx > minv_q)};
  end

  logic [SideW-1:0] side_q [NumStages];
  logic [XW-1:0]    a_x_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      side_q[0] <= side_in;
      for (int i = 1; i < NumStages; i++) begin
        side_q[i] <= side_q[i-1];
      end
      a_x_q <= x_d;
    end
  end

  // stage B: leading one and normalized fraction
  logic [slsd_pkg::ExpW-1:0]  e_d;
  logic [32:0]                shifted;
  logic [slsd_pkg::ExpW-1:0]  b_e_q;
  logic [slsd_pkg::FracW-1:0] b_f_q;

  always_comb begin
    e_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (a_x_q[i]) begin
        e_d = slsd_pkg::ExpW'(i);
      end
    end
    shifted = 33'(a_x_q) << (slsd_pkg::ExpW'(16) - e_d);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_e_q <= e_d;
      b_f_q <= shifted[slsd_pkg::FracW-1:0];
    end
  end

  // stage C: table interpolation
  logic [3:0]                idx;
  logic [11:0]               low;
  logic [16:0]               t0, t1, tdiff;
  logic [29:0]               interp;
  logic [slsd_pkg::LogW-1:0] lg_d, c_lg_q;

  always_comb begin
    idx    = b_f_q[15:12];
    low    = b_f_q[11:0];
    t0     = slsd_pkg::Log2Frac[{1'b0, idx}];
    t1     = slsd_pkg::Log2Frac[{1'b0, idx} + 5'd1];
    tdiff  = t1 - t0;
    interp = (30'(tdiff) * 30'(low) + 30'd2048) >> 12;
    lg_d   = slsd_pkg::LogW'(t0) + slsd_pkg::LogW'(interp) + {b_e_q, 16'b0};
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c_lg_q <= lg_d;
    end
  end

  // stage D: scale to tenths of a dB
  logic [slsd_pkg::ProdW-1:0]  prod;
  logic [slsd_pkg::LevelW-1:0] d_raw_q;

  assign prod = slsd_pkg::ProdW'(c_lg_q) * slsd_pkg::LogScale
              + (slsd_pkg::ProdW'(1) << 31);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      d_raw_q <= prod[42:32];
    end
  end

  // stage E: offset, clamp, band
  logic [slsd_pkg::SumW-1:0]   sum;
  logic [slsd_pkg::LevelW-1:0] level_d, e_level_q;
  slsd_pkg::band_e             band_d, e_band_q;

  always_comb begin
    sum = slsd_pkg::SumW'(ref_q) + slsd_pkg::SumW'(d_raw_q);
    if (sum < slsd_pkg::SumW'(slsd_pkg::LevelMin)) begin
      level_d = slsd_pkg::LevelMin;
    end else if (sum > slsd_pkg::SumW'(slsd_pkg::LevelMax)) begin
      level_d = slsd_pkg::LevelMax;
    end else begin
      level_d = sum[slsd_pkg::LevelW-1:0];
    end
    priority if (level_d < med_q) begin
      band_d = slsd_pkg::BandLow;
    end else if (level_d < high_q) begin
      band_d = slsd_pkg::BandMedium;
    end else begin
      band_d = slsd_pkg::BandHigh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      e_level_q <= level_d;
      e_band_q  <= band_d;
    end
  end

  assign item_data_o = {e_level_q, e_band_q, side_q[NumStages-1]};

endmodule

[rtl/core/slsd_fifo.sv]
// Two-entry request queue between the front end and the statistics back end.
module slsd_fifo #(
  parameter int unsigned Width = 43
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned Depth = slsd_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop, full;

  assign full         = (count_q == CntW'(Depth));
  assign push_ready_o = !full;
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !full;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count above depth");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue pointers differ");
`endif

endmodule

[rtl/core/slsd_back.sv]
// Back end: peak, floor and band time statistics with the result register.
module slsd_back #(
  parameter int unsigned SampleBits = 12,
  parameter int unsigned TimeBits = 32,
  parameter int unsigned ItemW = 43
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  logic [ItemW-1:0]                    item_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [slsd_pkg::LevelW-1:0]         level_tenths_o,
  output logic                                over_threshold_o,
  output logic [1:0]                          band_o,
  output logic [slsd_pkg::LevelW-1:0]         max_level_o,
  output logic [SampleBits-1:0]               max_sample_o,
  output logic [slsd_pkg::FloorW-1:0]         min_level_o,
  output logic [SampleBits-1:0]               min_sample_o,
  output logic [slsd_pkg::OutTimeW-1:0]       low_ms_o,
  output logic [slsd_pkg::OutTimeW-1:0]       medium_ms_o,
  output logic [slsd_pkg::OutTimeW-1:0]       high_ms_o
);

  logic [slsd_pkg::LevelW-1:0]   it_level;
  logic [1:0]                    it_band_bits;
  slsd_pkg::band_e               it_band;
  logic [SampleBits-1:0]         it_sample;
  logic [slsd_pkg::ElapsedW-1:0] it_elapsed;
  logic                          it_over, it_floor_ok;

  assign {it_level, it_band_bits, it_sample, it_elapsed, it_over, it_floor_ok} = item_data_i;
  assign it_band = slsd_pkg::band_e'(it_band_bits);

  logic out_valid_q, pop;

  assign pop          = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_ready_o = pop;
  assign out_valid_o  = out_valid_q;

  logic [slsd_pkg::LevelW-1:0] level_q, peak_q;
  logic                        over_q;
  slsd_pkg::band_e             band_q;
  logic [SampleBits-1:0]       peak_s_q, floor_s_q;
  logic [slsd_pkg::FloorW-1:0] floor_q;
  logic [TimeBits-1:0]         quiet_q, moderate_q, loud_q, acc_sel, acc_new;
  logic [TimeBits:0]           acc_sum;

  always_comb begin
    unique case (it_band)
      slsd_pkg::BandLow:    acc_sel = quiet_q;
      slsd_pkg::BandMedium: acc_sel = moderate_q;
      default:              acc_sel = loud_q;
    endcase
    acc_sum = (TimeBits + 1)'(acc_sel) + (TimeBits + 1)'(it_elapsed);
    acc_new = acc_sum[TimeBits] ? '1 : acc_sum[TimeBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      peak_q      <= '0;
      peak_s_q    <= '0;
      floor_q     <= slsd_pkg::FloorNone;
      floor_s_q   <= '1;
      quiet_q     <= '0;
      moderate_q  <= '0;
      loud_q      <= '0;
    end else begin
      out_valid_q <= pop || (out_valid_q && !out_ready_i);
      if (pop) begin
        unique case (it_band)
          slsd_pkg::BandLow:    quiet_q    <= acc_new;
          slsd_pkg::BandMedium: moderate_q <= acc_new;
          default:              loud_q     <= acc_new;
        endcase
        if (it_level > peak_q) begin
          peak_q   <= it_level;
          peak_s_q <= it_sample;
        end
        if ((slsd_pkg::FloorW'(it_level) < floor_q) && it_floor_ok) begin
          floor_q   <= slsd_pkg::FloorW'(it_level);
          floor_s_q <= it_sample;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      level_q <= it_level;
      over_q  <= it_over;
      band_q  <= it_band;
    end
  end

  logic [63:0] quiet_ext, moderate_ext, loud_ext;

  assign quiet_ext    = 64'(quiet_q);
  assign moderate_ext = 64'(moderate_q);
  assign loud_ext     = 64'(loud_q);

  assign level_tenths_o   = level_q;
  assign over_threshold_o = over_q;
  assign band_o           = 2'(band_q);
  assign max_level_o      = peak_q;
  assign max_sample_o     = peak_s_q;
  assign min_level_o      = floor_q;
  assign min_sample_o     = floor_s_q;
  assign low_ms_o         = quiet_ext[slsd_pkg::OutTimeW-1:0];
  assign medium_ms_o      = moderate_ext[slsd_pkg::OutTimeW-1:0];
  assign high_ms_o        = loud_ext[slsd_pkg::OutTimeW-1:0];

`ifndef SYNTH
  a_peak_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (peak_q >= $past(peak_q))) else $error("peak level dropped");
  a_floor_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (floor_q <= $past(floor_q))) else $error("floor level rose");
  a_times_one_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> ($stable(quiet_q) && $stable(moderate_q) && $stable(loud_q)))
    else $error("band time moved without a request");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(level_q) && $stable(peak_q)))
    else $error("result changed while stalled");
`endif

endmodule

[rtl/core/sound_level_statistics.sv]
// Top level of the sound level statistics block.
//
//   channel  direction  handshake                    payload
//   cfg      in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_ready_o      sample_i, elapsed_ms_i
//   out      out        out_valid_o / out_ready_i    level_tenths_o .. high_ms_o
//
// One request per cycle sustained while out_ready_i holds high; each
// request passes the five-stage log pipeline, the queue and the result
// register in turn. The statistics registers update once per request.
// Reset clears statistics to their idle values and loads default settings.
// A stalled result holds the back end; the two-entry queue then fills and
// stops the log pipeline, which in turn drops in_ready_o.
module sound_level_statistics #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slsd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11)-1:0] cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  logic [slsd_pkg::ElapsedW-1:0]       elapsed_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [slsd_pkg::LevelW-1:0]         level_tenths_o,
  output logic                                over_threshold_o,
  output logic [1:0]                          band_o,
  output logic [slsd_pkg::LevelW-1:0]         max_level_o,
  output logic [SAMPLE_BITS-1:0]              max_sample_o,
  output logic [slsd_pkg::FloorW-1:0]         min_level_o,
  output logic [SAMPLE_BITS-1:0]              min_sample_o,
  output logic [slsd_pkg::OutTimeW-1:0]       low_ms_o,
  output logic [slsd_pkg::OutTimeW-1:0]       medium_ms_o,
  output logic [slsd_pkg::OutTimeW-1:0]       high_ms_o
);

  localparam int unsigned CfgW = (SAMPLE_BITS > 11) ? SAMPLE_BITS : 11;
  localparam int unsigned ItemW = slsd_pkg::LevelW + 2 + SAMPLE_BITS
                                + slsd_pkg::ElapsedW + 2;

  logic             fr_valid, fr_ready, bk_valid, bk_ready;
  logic [ItemW-1:0] fr_data, bk_data;

  slsd_front #(
    .SampleBits(SAMPLE_BITS),
    .CfgW      (CfgW),
    .ItemW     (ItemW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .elapsed_ms_i(elapsed_ms_i),
    .item_valid_o(fr_valid),
    .item_ready_i(fr_ready),
    .item_data_o (fr_data)
  );

  slsd_fifo #(
    .Width(ItemW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i (fr_data),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (bk_data)
  );

  slsd_back #(
    .SampleBits(SAMPLE_BITS),
    .TimeBits  (TIME_BITS),
    .ItemW     (ItemW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (bk_valid),
    .item_ready_o    (bk_ready),
    .item_data_i     (bk_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_tenths_o  (level_tenths_o),
    .over_threshold_o(over_threshold_o),
    .band_o          (band_o),
    .max_level_o     (max_level_o),
    .max_sample_o    (max_sample_o),
    .min_level_o     (min_level_o),
    .min_sample_o    (min_sample_o),
    .low_ms_o        (low_ms_o),
    .medium_ms_o     (medium_ms_o),
    .high_ms_o       (high_ms_o)
  );

endmodule
